// ----- src/cbc_pkg.sv -----
package cbc_pkg;

  // cartridge RAM geometry
  localparam int RAM_BYTES = 32768;
  localparam int RAM_AW    = $clog2(RAM_BYTES);
  // banked RAM offset before the size wrap: 2-bit bank and 13-bit window offset
  localparam int EFF_W     = 15;
  localparam int ROM_AW    = 23;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CART_KIND = 2'd0,
    CFG_ROM_LOG2  = 2'd1,
    CFG_RAM_CODE  = 2'd2
  } cfg_idx_e;

  // cartridge kinds that decode bank selects
  localparam logic [1:0] CART_MBC1     = 2'd1;
  localparam logic [1:0] CART_MBC1_RAM = 2'd2;

  // RAM size codes from the cartridge header
  localparam logic [2:0] RAM_CODE_8K   = 3'd1;
  localparam logic [2:0] RAM_CODE_32K  = 3'd2;
  localparam logic [2:0] RAM_CODE_128K = 3'd3;
  localparam logic [2:0] RAM_CODE_64K  = 3'd4;

  // ROM size clamp
  localparam logic [4:0] ROM_LOG2_MIN = 5'd15;
  localparam logic [4:0] ROM_LOG2_MAX = 5'd23;

  // bus operation
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ROM   = 2'd0,
    KIND_RAM   = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_WRITE = 2'd3
  } result_kind_e;

  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

  // decoded transaction heading for the result stage
  typedef struct packed {
    result_kind_e      kind;
    logic [ROM_AW-1:0] rom_addr;
  } dec_t;

  // one memory access: write port and read port
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [RAM_AW-1:0] raddr;
  } mem_req_t;

  // log2 of the coded RAM size, zero when there is no RAM
  function automatic logic [4:0] ram_log2(input logic [2:0] code);
    logic [4:0] lg;
    case (code)
      RAM_CODE_8K:   lg = 5'd13;
      RAM_CODE_32K:  lg = 5'd15;
      RAM_CODE_128K: lg = 5'd17;
      RAM_CODE_64K:  lg = 5'd16;
      default:       lg = 5'd0;
    endcase
    return lg;
  endfunction

endpackage

// ----- src/cbc_ram.sv -----
module cbc_ram import cbc_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [RAM_BYTES];
  logic [DATA_W-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cbc_clear.sv -----
module cbc_clear import cbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  output logic     busy_o,
  output mem_req_t req_o
);

  logic              busy_q, busy_d;
  logic [RAM_AW-1:0] idx_q, idx_d;

  // sweep every RAM entry to zero after reset
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (busy_q) begin
      idx_d = idx_q + RAM_AW'(1);
      if (idx_q == {RAM_AW{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  assign busy_o      = busy_q;
  assign req_o.we    = busy_q;
  assign req_o.waddr = idx_q;
  assign req_o.wdata = '0;
  assign req_o.re    = 1'b0;
  assign req_o.raddr = '0;

endmodule

// ----- src/cbc_mapper.sv -----
module cbc_mapper import cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic                  operation_i,
  input  logic [ADDR_W-1:0]     bus_address_i,
  input  logic [DATA_W-1:0]     write_data_i,
  output dec_t                  dec_o,
  output mem_req_t              req_o
);

  logic [1:0]        cart_kind_q, cart_kind_d;
  logic [4:0]        rom_log2_q, rom_log2_d;
  logic [2:0]        ram_code_q, ram_code_d;
  logic [4:0]        rom_bank_q, rom_bank_d;
  logic              ram_en_q, ram_en_d;
  logic [1:0]        ram_sel_q, ram_sel_d;

  logic [4:0]        rom_lg;
  logic [ROM_AW-1:0] rom_mask;
  logic [ROM_AW-1:0] rom_banked;
  logic [4:0]        ram_lg_raw;
  logic [4:0]        ram_lg;
  logic [EFF_W-1:0]  ram_mask;
  logic [EFF_W-1:0]  ram_eff;
  logic [EFF_W-1:0]  ram_off;
  logic              ram_win;
  logic              ram_ok;
  logic              is_read;

  // address decode
  assign is_read    = (operation_i == OP_READ);
  assign ram_win    = (bus_address_i[15:13] == 3'b101);
  assign ram_lg_raw = ram_log2(ram_code_q);
  assign ram_ok     = ram_en_q && (ram_lg_raw != 5'd0);
  assign ram_lg     = (ram_lg_raw > 5'(RAM_AW)) ? 5'(RAM_AW) : ram_lg_raw;
  assign ram_eff    = {ram_sel_q, bus_address_i[12:0]};

  // ROM size clamp
  always_comb begin
    if (rom_log2_q < ROM_LOG2_MIN) begin
      rom_lg = ROM_LOG2_MIN;
    end else if (rom_log2_q > ROM_LOG2_MAX) begin
      rom_lg = ROM_LOG2_MAX;
    end else begin
      rom_lg = rom_log2_q;
    end
  end

  // size masks: power-of-two wrap of ROM and RAM addresses
  always_comb begin
    for (int i = 0; i < ROM_AW; i++) begin
      rom_mask[i] = (5'(i) < rom_lg);
    end
    for (int j = 0; j < EFF_W; j++) begin
      ram_mask[j] = (5'(j) < ram_lg);
    end
  end

  assign rom_banked = {4'b0, rom_bank_q, bus_address_i[13:0]} & rom_mask;
  assign ram_off    = ram_eff & ram_mask;

  // read result decode
  always_comb begin
    dec_o.kind     = KIND_WRITE;
    dec_o.rom_addr = '0;
    if (is_read) begin
      if (!bus_address_i[15]) begin
        dec_o.kind = KIND_ROM;
        if (!bus_address_i[14]) begin
          dec_o.rom_addr = {7'b0, bus_address_i};
        end else begin
          dec_o.rom_addr = rom_banked;
        end
      end else if (ram_win && ram_ok) begin
        dec_o.kind = KIND_RAM;
      end else begin
        dec_o.kind = KIND_OPEN;
      end
    end
  end

  // RAM access issued in the accept cycle
  assign req_o.we    = accept_i && !is_read && ram_win && ram_ok;
  assign req_o.waddr = ram_off[RAM_AW-1:0];
  assign req_o.wdata = write_data_i;
  assign req_o.re    = accept_i && is_read && ram_win && ram_ok;
  assign req_o.raddr = ram_off[RAM_AW-1:0];

  // configuration and bank register updates
  always_comb begin
    cart_kind_d = cart_kind_q;
    rom_log2_d  = rom_log2_q;
    ram_code_d  = ram_code_q;
    rom_bank_d  = rom_bank_q;
    ram_en_d    = ram_en_q;
    ram_sel_d   = ram_sel_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CART_KIND: cart_kind_d = cfg_data_i[1:0];
        CFG_ROM_LOG2:  rom_log2_d  = cfg_data_i;
        CFG_RAM_CODE:  ram_code_d  = cfg_data_i[2:0];
        default:       ;
      endcase
    end
    if (accept_i && !is_read) begin
      unique case (bus_address_i[15:13])
        3'b000: ram_en_d = (write_data_i[3:0] == 4'hA);
        3'b001: begin
          if (cart_kind_q == CART_MBC1 || cart_kind_q == CART_MBC1_RAM) begin
            rom_bank_d = (write_data_i[4:0] == 5'd0) ? 5'd1 : write_data_i[4:0];
          end
        end
        3'b010: begin
          if (cart_kind_q == CART_MBC1_RAM) begin
            ram_sel_d = write_data_i[1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_kind_q <= '0;
      rom_log2_q  <= ROM_LOG2_MIN;
      ram_code_q  <= '0;
      rom_bank_q  <= 5'd1;
      ram_en_q    <= 1'b0;
      ram_sel_q   <= '0;
    end else begin
      cart_kind_q <= cart_kind_d;
      rom_log2_q  <= rom_log2_d;
      ram_code_q  <= ram_code_d;
      rom_bank_q  <= rom_bank_d;
      ram_en_q    <= ram_en_d;
      ram_sel_q   <= ram_sel_d;
    end
  end

endmodule

// ----- src/cartridge_bank_controller.sv -----
// Cartridge bank controller: a simplified MBC1 mapper with on-chip cartridge RAM.
// Input channel (in_valid_i/in_ready_o): one CPU bus transaction, a read or a
// write, with address and data. Output channel (out_valid_o/out_ready_i): one
// result per transaction: ROM fetch address, RAM byte, open bus (0xFF) or a
// write acknowledge. ROM itself lives outside; the block only maps the address.
// A transaction passes the middle stage and the output register. One is accepted
// every cycle while in_ready_o is high, as set by the single-port-pair RAM,
// read or written in the accept cycle, with registered read data next cycle.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets cart kind, ROM
// size and RAM size code; write it only while no transaction is in flight.
// After reset the RAM is swept to zero, one byte per cycle, over all RAM_BYTES
// (32768) bytes; in_ready_o stays low for that time, configuration writes are
// taken as usual. Bank registers reset to ROM bank 1, RAM disabled, RAM bank 0.
// When the receiver stalls, the result sits in the output register and one more
// transaction waits in the middle stage; then in_ready_o drops until the output
// drains.
module cartridge_bank_controller import cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [ADDR_W-1:0]     bus_address_i,
  input  logic [DATA_W-1:0]     write_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            result_kind_o,
  output logic [ROM_AW-1:0]     rom_address_o,
  output logic [DATA_W-1:0]     read_data_o
);

  logic              accept;
  logic              clr_busy;
  dec_t              dec;
  mem_req_t          map_req;
  mem_req_t          clr_req;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  logic              s1_valid_q, s1_valid_d;
  dec_t              s1_dec_q;
  logic              s1_move;
  logic              out_valid_q, out_valid_d;
  result_kind_e      out_kind_q;
  logic [ROM_AW-1:0] out_rom_q;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  cbc_mapper u_mapper (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .dec_o         (dec),
    .req_o         (map_req)
  );

  cbc_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .req_o  (clr_req)
  );

  // clear sweep owns the RAM until done
  assign mem_req = clr_busy ? clr_req : map_req;

  cbc_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // handshake: middle stage advances when the output register is free or draining
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy && (!s1_valid_q || s1_move);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // read data select for the result
  always_comb begin
    case (s1_dec_q.kind)
      KIND_RAM:  out_data_d = mem_rdata;
      KIND_OPEN: out_data_d = OPEN_BUS;
      default:   out_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dec_q <= dec;
    end
    if (s1_move) begin
      out_kind_q <= s1_dec_q.kind;
      out_rom_q  <= s1_dec_q.rom_addr;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign rom_address_o = out_rom_q;
  assign read_data_o   = out_data_q;

  // no transaction is taken while the RAM is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o)
    else $error("transaction accepted during RAM clear");

  // an accepted transaction always occupies the middle stage next cycle
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction lost");

  // the mapper never reads and writes RAM in one cycle
  a_one_ram_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(map_req.we && map_req.re))
    else $error("RAM read and write issued together");

  // a result held by the receiver keeps its RAM byte
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(read_data_o))
    else $error("stalled result data changed");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench import cbc_pkg::*;;

  localparam int IDLE_LIMIT  = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 10;

  // one expected reply to a bus transaction
  typedef struct packed {
    result_kind_e      kind;
    logic [ROM_AW-1:0] rom_addr;
    logic [DATA_W-1:0] rdata;
  } bus_reply_t;

  // mapper state mirror plus the queue of replies still owed by the block
  class mbc_scoreboard;
    logic [1:0]        cart_kind;
    logic [4:0]        rom_log2;
    logic [2:0]        ram_code;
    logic [4:0]        rom_bank;
    logic              ram_on;
    logic [1:0]        ram_sel;
    logic [DATA_W-1:0] cart_ram [RAM_BYTES];
    bus_reply_t        pending_replies[$];
    int                mismatches;

    function new();
      cart_kind  = '0;
      rom_log2   = ROM_LOG2_MIN;
      ram_code   = '0;
      rom_bank   = 5'd1;
      ram_on     = 1'b0;
      ram_sel    = '0;
      mismatches = 0;
      foreach (cart_ram[i]) cart_ram[i] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_CART_KIND: cart_kind = value[1:0];
        CFG_ROM_LOG2:  rom_log2  = value;
        CFG_RAM_CODE:  ram_code  = value[2:0];
        default: ;
      endcase
    endfunction

    // bytes of RAM backed by the store, zero when the cartridge has none
    function int unsigned ram_span();
      int unsigned span;
      case (ram_code)
        RAM_CODE_8K:   span = 8192;
        RAM_CODE_32K:  span = 32768;
        RAM_CODE_128K: span = 131072;
        RAM_CODE_64K:  span = 65536;
        default:       span = 0;
      endcase
      return (span > RAM_BYTES) ? RAM_BYTES : span;
    endfunction

    // apply one accepted transaction to the mirror and queue its reply
    function void note_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      bus_reply_t  reply;
      int unsigned span;
      int unsigned lg;
      int unsigned ram_idx;
      logic        ram_hit;
      span    = ram_span();
      ram_hit = (addr >= 16'hA000) && (addr < 16'hC000) && ram_on && (span != 0);
      ram_idx = 0;
      if (span != 0) ram_idx = (32'(addr[12:0]) + 32'(ram_sel) * 32'h2000) % span;
      reply.kind     = KIND_OPEN;
      reply.rom_addr = '0;
      reply.rdata    = '0;
      if (op == OP_READ) begin
        if (addr < 16'h4000) begin
          reply.kind     = KIND_ROM;
          reply.rom_addr = ROM_AW'(addr);
        end else if (addr < 16'h8000) begin
          // banked window, wrapped to the ROM size after clamping it
          lg = rom_log2;
          if (lg < ROM_LOG2_MIN) lg = ROM_LOG2_MIN;
          if (lg > ROM_LOG2_MAX) lg = ROM_LOG2_MAX;
          reply.kind     = KIND_ROM;
          reply.rom_addr = ROM_AW'((32'(addr[13:0]) + 32'(rom_bank) * 32'h4000) &
                                   ((32'd1 << lg) - 32'd1));
        end else if (ram_hit) begin
          reply.kind  = KIND_RAM;
          reply.rdata = cart_ram[ram_idx];
        end else begin
          reply.rdata = OPEN_BUS;
        end
      end else begin
        reply.kind = KIND_WRITE;
        if (addr < 16'h2000) begin
          ram_on = (data[3:0] == 4'hA);
        end else if (addr < 16'h4000) begin
          if (cart_kind == CART_MBC1 || cart_kind == CART_MBC1_RAM)
            rom_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
        end else if (addr < 16'h6000) begin
          if (cart_kind == CART_MBC1_RAM) ram_sel = data[1:0];
        end else if (ram_hit) begin
          cart_ram[ram_idx] = data;
        end
      end
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(logic [1:0] kind, logic [ROM_AW-1:0] rom_addr,
                              logic [DATA_W-1:0] rdata);
      bus_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d rom_address %h read_data %h",
                   kind, rom_addr, rdata);
        return;
      end
      want = pending_replies.pop_front();
      if (kind !== want.kind || rom_addr !== want.rom_addr || rdata !== want.rdata) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch: expected kind %0d rom_address %h read_data %h,",
                    " got kind %0d rom_address %h read_data %h"},
                   want.kind, want.rom_addr, want.rdata, kind, rom_addr, rdata);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [ADDR_W-1:0]     bus_address_i;
  logic [DATA_W-1:0]     write_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            result_kind_o;
  logic [ROM_AW-1:0]     rom_address_o;
  logic [DATA_W-1:0]     read_data_o;

  mbc_scoreboard sb;
  int            stall_left    = 0;
  bit            hold_request  = 1'b0;
  bit            calm          = 1'b0;
  int            idle_cycles   = 0;

  cartridge_bank_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .rom_address_o (rom_address_o),
    .read_data_o   (read_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result check on every accepted output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply(result_kind_o, rom_address_o, read_data_o);
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[cartridge_bank_controller] ERROR");
        $finish;
      end
    end
  end

  task automatic write_regs(logic [4:0] kind, logic [4:0] log2, logic [4:0] code);
    logic [4:0] vals [3];
    vals = '{kind, log2, code};
    for (int r = 0; r < 3; r++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(r);
      cfg_data_i <= vals[r];
      @(posedge clk_i);
      sb.write_reg(cfg_idx_e'(r), vals[r]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    bus_address_i <= addr;
    write_data_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(op, addr, data);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // stop offering and wait until every reply is back and the pipe is empty
  task automatic drain_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random transactions, biased toward the mapped ranges
  task automatic run_random(int count, bit sender_idles);
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int                region;
    for (int i = 0; i < count; i++) begin
      region = $urandom_range(0, 11);
      data   = DATA_W'($urandom);
      op     = 1'($urandom_range(0, 1));
      case (region)
        0: begin
          addr = ADDR_W'($urandom_range(16'h0000, 16'h1FFF));
          op   = ($urandom_range(0, 3) != 0) ? OP_WRITE : OP_READ;
          if ($urandom_range(0, 1)) data[3:0] = 4'hA;
        end
        1: addr = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
        2: addr = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
        3: addr = ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
        4, 5, 6, 7: addr = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
        8: begin
          addr = ADDR_W'($urandom_range(16'h4000, 16'h7FFF));
          op   = OP_READ;
        end
        10: addr = ADDR_W'($urandom_range(16'h8000, 16'h9FFF));
        11: addr = ADDR_W'($urandom_range(16'hC000, 16'hFFFF));
        default: addr = ADDR_W'($urandom);
      endcase
      send_access(op, addr, data);
      if (sender_idles && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 10));
    end
  endtask

  task automatic run_phase(logic [4:0] kind, logic [4:0] log2, logic [4:0] code, int count);
    drain_replies();
    write_regs(kind, log2, code);
    run_random(count, 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_CART_KIND;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    operation_i   = OP_READ;
    bus_address_i = '0;
    write_data_i  = '0;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: map edges, enable and bank selects, ignored writes
    write_regs(5'(CART_MBC1_RAM), ROM_LOG2_MAX, 5'(RAM_CODE_32K));
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_READ,  16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'h55);
    send_access(OP_WRITE, 16'h1FFF, 8'h1A);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'hFF);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'hE0);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h03);
    send_access(OP_WRITE, 16'hBFFF, 8'h5A);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h5FFF, 8'hFC);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'h12);
    send_access(OP_WRITE, 16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h0000, 8'h00);
    send_access(OP_READ,  16'hBFFF, 8'h00);

    // random phases over the configuration space
    run_phase(5'(CART_MBC1_RAM), ROM_LOG2_MIN, 5'(RAM_CODE_8K), 160);

    // long receiver hold while the sender keeps offering
    drain_replies();
    write_regs(5'(CART_MBC1), ROM_LOG2_MAX, 5'(RAM_CODE_32K));
    hold_request = 1'b1;
    run_random(40, 1'b0);
    run_random(120, 1'b1);

    // unused cart kind, ROM size above range, 128K code
    run_phase(5'd31, 5'd31, 5'(RAM_CODE_128K), 160);
    // rom only with RAM present, ROM size below range
    run_phase(5'd0, 5'd0, 5'(RAM_CODE_64K), 160);
    run_phase(5'h1E, 5'd19, 5'd5, 160);
    run_phase(5'(CART_MBC1_RAM), 5'd17, 5'd7, 160);
    run_phase(5'(CART_MBC1), 5'd20, 5'd6, 160);

    // sender waits mid-phase until all replies are back
    drain_replies();
    write_regs(5'(CART_MBC1_RAM), 5'd22, 5'(RAM_CODE_32K));
    run_random(80, 1'b1);
    drain_replies();
    run_random(80, 1'b1);

    // last part: no idling on either side
    drain_replies();
    write_regs(5'(CART_MBC1_RAM), 5'd16, 5'(RAM_CODE_128K));
    calm = 1'b1;
    run_random(160, 1'b0);

    drain_replies();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("[cartridge_bank_controller] OK");
    end else begin
      $display("[cartridge_bank_controller] ERROR");
    end
    $finish;
  end

endmodule
